@@ rtl/core/sdbp_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - shared package
// Item types, opcodes, internal operation codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbp_pkg;

  // input opcodes
  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_CMD8  = 2'd1,
    OP_CMD16 = 2'd2,
    OP_FLUSH = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [8:0]  bit_length_minus_one;
    logic        dc_level;
    logic        last_word;
    logic        last;
  } out_item_t;

  // operations handed from the front to the back
  typedef enum logic [2:0] {
    UOP_SYM9   = 3'd0,  // one nine-bit symbol in arg[8:0]
    UOP_SYM9X2 = 3'd1,  // two command symbols: arg[15:8] then arg[7:0]
    UOP_BYTE8  = 3'd2,  // one whole data byte in arg[7:0]
    UOP_FLUSH  = 3'd3,  // send the buffer
    UOP_CMD    = 3'd4   // send the buffer, then command word in arg
  } uop_kind_e;

  typedef struct packed {
    uop_kind_e   kind;
    logic [15:0] arg;
    logic        wide;  // sixteen-bit command
  } uop_t;

  localparam logic [8:0] DATA_FLAG = 9'h100;
  localparam logic [8:0] CMD8_LEN  = 9'd7;
  localparam logic [8:0] CMD16_LEN = 9'd15;

endpackage

`default_nettype wire

@@ rtl/core/spi_display_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - top level
// Packs display bytes into 32-bit SPI transfer words, with optional nine-bit symbols.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_item_i): one item is a data
//    byte, an 8- or 16-bit command, or a flush request. An item is taken on a
//    clock edge with valid high and stall low.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): one item per
//    32-bit transfer word, with its length, dc level and end markers.
//  - cfg_we_i / cfg_wdata_i write nine_bit_mode; a new value drops pending
//    bits. Write it only while the block is idle.
//  - Throughput: the queue takes one item per cycle until full. The back end
//    pops an operation only while idle; a nine-bit sixteen-bit command adds
//    a second-symbol step, a flush sends up to BUFFER_BITS/32 words, then
//    any command word. Data bytes that cause no flush sustain one per cycle.
//  - Path: a taken item is popped by the back end, whose flush or command
//    state registers the first word in the output register; the low symbol
//    of a nine-bit sixteen-bit command passes the second-symbol state first.
//  - A stalled output holds its word; the back end waits on it while the
//    QUEUE_DEPTH-entry queue keeps taking items, then stalls the input.
//  - Reset empties the queue and buffer count and clears the mode to
//    eight-bit. Buffer contents need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_display_bit_packer_unit #(
  parameter int unsigned BUFFER_BITS = 512,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sdbp_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sdbp_pkg::out_item_t     out_item_o
);

  logic           mode_q, mode_d;
  logic           clear;
  logic           push, q_full, q_valid, q_pop;
  sdbp_pkg::uop_t push_uop, q_uop;

  // mode register; a change throws away the partially filled buffer
  assign clear  = cfg_we_i && (cfg_wdata_i != mode_q);
  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // front: decode items into buffer operations
  sdbp_front u_front (
    .in_valid_i      (in_valid_i),
    .in_item_i       (in_item_i),
    .in_stall_o      (in_stall_o),
    .nine_bit_mode_i (mode_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .uop_o           (push_uop)
  );

  // queue decouples decode from flush bursts
  sdbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_uop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_uop),
    .pop_i       (q_pop)
  );

  // back: buffer, count, flush sequencing and output register
  sdbp_back #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .q_valid_i   (q_valid),
    .q_data_i    (q_uop),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ rtl/core/sdbp_front.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - front end
// Accepts input items and turns them into buffer operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_front (
  input  wire logic                in_valid_i,
  input  wire sdbp_pkg::in_item_t  in_item_i,
  output logic                     in_stall_o,
  input  wire logic                nine_bit_mode_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output sdbp_pkg::uop_t           uop_o
);

  logic [7:0] lo_byte;
  logic [7:0] hi_byte;

  assign lo_byte    = in_item_i.value[7:0];
  assign hi_byte    = in_item_i.value[15:8];
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    uop_o.kind = sdbp_pkg::UOP_FLUSH;
    uop_o.arg  = '0;
    uop_o.wide = 1'b0;
    unique case (in_item_i.opcode)
      sdbp_pkg::OP_FLUSH: begin
        uop_o.kind = sdbp_pkg::UOP_FLUSH;
      end
      sdbp_pkg::OP_DATA: begin
        if (nine_bit_mode_i) begin
          uop_o.kind = sdbp_pkg::UOP_SYM9;
          uop_o.arg  = {7'b0, sdbp_pkg::DATA_FLAG | {1'b0, lo_byte}};
        end else begin
          uop_o.kind = sdbp_pkg::UOP_BYTE8;
          uop_o.arg  = {8'b0, lo_byte};
        end
      end
      sdbp_pkg::OP_CMD8: begin
        if (nine_bit_mode_i) begin
          uop_o.kind = sdbp_pkg::UOP_SYM9;
          uop_o.arg  = {8'b0, lo_byte};
        end else begin
          uop_o.kind = sdbp_pkg::UOP_CMD;
          uop_o.arg  = {8'b0, lo_byte};
        end
      end
      sdbp_pkg::OP_CMD16: begin
        if (nine_bit_mode_i) begin
          uop_o.kind = sdbp_pkg::UOP_SYM9X2;
          uop_o.arg  = {hi_byte, lo_byte};
        end else begin
          // high byte goes out first: it sits in the low byte of the word
          uop_o.kind = sdbp_pkg::UOP_CMD;
          uop_o.arg  = {lo_byte, hi_byte};
          uop_o.wide = 1'b1;
        end
      end
      default: begin
        uop_o.kind = sdbp_pkg::UOP_FLUSH;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/sdbp_queue.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - operation queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sdbp_pkg::uop_t push_data_i,
  output logic                full_o,
  output logic                valid_o,
  output sdbp_pkg::uop_t      data_o,
  input  wire logic           pop_i
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  sdbp_pkg::uop_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sdbp_back.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - back end
// Holds the bit buffer and count, runs flushes and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbp_back #(
  parameter int unsigned BUFFER_BITS = 512
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           q_valid_i,
  input  wire sdbp_pkg::uop_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  output sdbp_pkg::out_item_t out_item_o,
  input  wire logic           out_stall_i
);

  localparam int unsigned WORDS = BUFFER_BITS / 32;
  localparam int unsigned BYTES = BUFFER_BITS / 8;
  localparam int unsigned CW    = $clog2(BUFFER_BITS + 1);
  localparam int unsigned WIW   = $clog2(WORDS);
  localparam int unsigned BI    = $clog2(BYTES);
  localparam logic [CW-1:0] NINE_LIM = CW'(BUFFER_BITS - 8);
  localparam logic [CW-1:0] FULL_LIM = CW'(BUFFER_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_SYM2  = 2'd2;
  localparam logic [1:0] ST_CMD   = 2'd3;

  localparam logic [1:0] POST_NONE = 2'd0;
  localparam logic [1:0] POST_SYM  = 2'd1;
  localparam logic [1:0] POST_CMD  = 2'd2;

  logic [WORDS-1:0][31:0] buf_q, buf_d;
  logic [7:0]             tail_q, tail_d;   // last partial byte written
  logic [CW-1:0]          count_q, count_d, count_wr;
  logic [1:0]             state_q, state_d;
  logic [1:0]             post_q, post_d;
  logic [WIW-1:0]         widx_q, widx_d;
  logic [8:0]             symb_q, symb_d;
  logic [15:0]            cmd_q, cmd_d;
  logic                   cmd_wide_q, cmd_wide_d;
  sdbp_pkg::out_item_t    out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic           wr_sym_en, wr_byte_en;
  logic [8:0]     wr_sym;
  logic [7:0]     wr_byte;
  logic [CW-1:0]  sum9, sum8;
  logic           trig9, trig8;
  logic           emit_ok, emit, flush_done;
  logic [CW-1:0]  cm1, rem;
  logic [5:0]     remc;
  logic [31:0]    mask32, flush_word;
  logic           is_final;

  assign emit_ok = !out_valid_q || !out_stall_i;
  assign sum9    = count_q + CW'(9);
  assign sum8    = count_q + CW'(8);
  assign trig9   = (sum9 >= NINE_LIM);
  assign trig8   = (sum8 >= FULL_LIM);

  // buffer write: a nine-bit symbol lands MSB first at the bit count, a byte lands whole
  always_comb begin
    logic [2:0]    sh;
    logic [BI-1:0] idx;
    logic [BI:0]   nidx;
    logic [15:0]   shifted;
    logic [7:0]    head;
    sh       = count_q[2:0];
    idx      = count_q[3 +: BI];
    nidx     = {1'b0, idx} + 1'b1;
    shifted  = {wr_sym, 7'b0} >> sh;
    head     = (sh != 3'd0) ? (tail_q | shifted[15:8]) : shifted[15:8];
    buf_d    = buf_q;
    tail_d   = tail_q;
    count_wr = count_q;
    if (wr_sym_en) begin
      buf_d[idx[BI-1:2]][{idx[1:0], 3'b000} +: 8] = head;
      if (nidx < (BI + 1)'(BYTES)) begin
        buf_d[nidx[BI-1:2]][{nidx[1:0], 3'b000} +: 8] = shifted[7:0];
      end
      tail_d   = shifted[7:0];
      count_wr = sum9;
    end else if (wr_byte_en) begin
      buf_d[idx[BI-1:2]][{idx[1:0], 3'b000} +: 8] = wr_byte;
      count_wr = sum8;
    end
  end

  // flush word: bits past the length go out as zero
  assign cm1      = count_q - CW'(1);
  assign rem      = count_q - CW'({widx_q, 5'b00000});
  assign remc     = (rem >= CW'(32)) ? 6'd32 : rem[5:0];
  assign is_final = (widx_q == cm1[5 +: WIW]);

  always_comb begin
    logic [5:0] lo;
    logic [2:0] k;
    mask32 = '0;
    for (int b = 0; b < 4; b++) begin
      lo = 6'(8 * b);
      k  = 3'(remc - lo);
      if (remc >= lo + 6'd8) begin
        mask32[8*b +: 8] = 8'hFF;
      end else if (remc > lo) begin
        mask32[8*b +: 8] = ~(8'hFF >> k);
      end
    end
  end

  assign flush_word = buf_q[widx_q] & mask32;

  always_comb begin
    state_d    = state_q;
    post_d     = post_q;
    widx_d     = widx_q;
    symb_d     = symb_q;
    cmd_d      = cmd_q;
    cmd_wide_d = cmd_wide_q;
    wr_sym_en  = 1'b0;
    wr_byte_en = 1'b0;
    wr_sym     = q_data_i.arg[8:0];
    wr_byte    = q_data_i.arg[7:0];
    q_pop_o    = 1'b0;
    emit       = 1'b0;
    flush_done = 1'b0;
    out_d      = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          widx_d  = '0;
          post_d  = POST_NONE;
          unique case (q_data_i.kind)
            sdbp_pkg::UOP_SYM9: begin
              wr_sym_en = 1'b1;
              if (trig9) begin
                state_d = ST_FLUSH;
              end
            end
            sdbp_pkg::UOP_SYM9X2: begin
              wr_sym_en = 1'b1;
              wr_sym    = {1'b0, q_data_i.arg[15:8]};
              symb_d    = {1'b0, q_data_i.arg[7:0]};
              if (trig9) begin
                state_d = ST_FLUSH;
                post_d  = POST_SYM;
              end else begin
                state_d = ST_SYM2;
              end
            end
            sdbp_pkg::UOP_BYTE8: begin
              wr_byte_en = 1'b1;
              if (trig8) begin
                state_d = ST_FLUSH;
              end
            end
            sdbp_pkg::UOP_FLUSH: begin
              if (count_q != '0) begin
                state_d = ST_FLUSH;
              end
            end
            sdbp_pkg::UOP_CMD: begin
              cmd_d      = q_data_i.arg;
              cmd_wide_d = q_data_i.wide;
              if (count_q != '0) begin
                state_d = ST_FLUSH;
                post_d  = POST_CMD;
              end else begin
                state_d = ST_CMD;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          emit                       = 1'b1;
          out_d.word                 = flush_word;
          out_d.bit_length_minus_one = 9'(cm1);
          out_d.dc_level             = 1'b1;
          out_d.last_word            = is_final;
          // a second symbol after a flush never flushes again
          out_d.last                 = is_final && (post_q != POST_CMD);
          widx_d                     = widx_q + 1'b1;
          if (is_final) begin
            flush_done = 1'b1;
            widx_d     = '0;
            unique case (post_q)
              POST_SYM: state_d = ST_SYM2;
              POST_CMD: state_d = ST_CMD;
              default:  state_d = ST_IDLE;
            endcase
          end
        end
      end
      ST_SYM2: begin
        wr_sym_en = 1'b1;
        wr_sym    = symb_q;
        post_d    = POST_NONE;
        widx_d    = '0;
        state_d   = trig9 ? ST_FLUSH : ST_IDLE;
      end
      ST_CMD: begin
        if (emit_ok) begin
          emit                       = 1'b1;
          out_d.word                 = cmd_wide_q ? {16'b0, cmd_q} : {24'b0, cmd_q[7:0]};
          out_d.bit_length_minus_one = cmd_wide_q ? sdbp_pkg::CMD16_LEN : sdbp_pkg::CMD8_LEN;
          out_d.dc_level             = 1'b0;
          out_d.last_word            = 1'b1;
          out_d.last                 = 1'b1;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (clear_i) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    count_d = count_wr;
    if (clear_i || flush_done) begin
      count_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      post_q      <= POST_NONE;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      post_q      <= post_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    tail_q     <= tail_d;
    symb_q     <= symb_d;
    cmd_q      <= cmd_d;
    cmd_wide_q <= cmd_wide_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> count_q != '0)
    else $error("flush running on an empty buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_LIM)
    else $error("bit count past buffer size");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && emit_ok && is_final) |=> count_q == '0)
    else $error("bit count not cleared after final flush word");

  a_last_on_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.last || out_q.last_word))
    else $error("item end flagged inside a transfer");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && q_valid_i))
    else $error("queue popped while busy");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// SPI display bit packer - testbench
// Drives display bytes, commands and flush requests into the packer in both
// symbol modes. A built-in predictor mirrors the bit buffer and works out
// every transfer word. Results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned BUF_BITS       = 512;
  localparam int unsigned BUF_BYTES      = BUF_BITS / 8;
  localparam int unsigned NINE_FLUSH_AT  = BUF_BITS - 8;
  localparam int unsigned SETTLE_CYCLES  = 20;    // queue plus back end, with margin
  localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles without any handshake

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs. Every input has a known value at time 0.
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i  = 1'b0;
  sdbp_pkg::in_item_t  in_item_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  sdbp_pkg::out_item_t out_item_o;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  spi_display_bit_packer_unit #(
    .BUFFER_BITS(BUF_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  sdbp_pkg::in_item_t  pending_items[$];   // items waiting for the driver
  sdbp_pkg::out_item_t expected_words[$];  // predicted transfer words, oldest first
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned words_checked  = 0;
  int unsigned full_flushes   = 0;  // flushes forced by a full buffer
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_tokens    = 0;  // bumped by the stimulus to ask for a hold-off

  // --------------------------------------------------------------------------
  // Predictor: shadow copy of the bit buffer, fill level and mode.
  // Byte k of the buffer is word k/4, bits 8*(k%4); bits fill MSB first.
  // --------------------------------------------------------------------------
  logic [7:0]  shadow_bytes[BUF_BYTES];
  int unsigned fill_bits  = 0;
  logic        nine_mode  = 1'b0;

  // Send everything buffered: ceil(bits/32) words, data level, length bits-1.
  // Only bytes below the fill level are read, and a partial last byte keeps
  // its top bits only, so stale buffer content never shows.
  function automatic void send_buffer();
    int unsigned n_words, i, b, k, keep;
    logic [31:0] w;
    logic [7:0]  byt;
    if (fill_bits == 0)
      return;
    n_words = (fill_bits + 31) / 32;
    for (i = 0; i < n_words; i++) begin
      w = '0;
      for (b = 0; b < 4; b++) begin
        k   = 4 * i + b;
        byt = '0;
        if (8 * k < fill_bits) begin
          keep = fill_bits - 8 * k;
          byt  = shadow_bytes[k];
          if (keep < 8)
            byt &= 8'hFF << (8 - keep);
        end
        w[8*b +: 8] = byt;
      end
      expected_words.push_back('{word: w, bit_length_minus_one: 9'(fill_bits - 1),
                                 dc_level: 1'b1, last_word: (i + 1 == n_words),
                                 last: 1'b0});
    end
    fill_bits = 0;
  endfunction

  // Nine-bit symbol, packed MSB first straddling byte boundaries.
  function automatic void pack_symbol9(logic [8:0] sym);
    int unsigned idx, sh;
    logic [15:0] s;
    idx = fill_bits >> 3;
    sh  = fill_bits & 7;
    s   = {7'b0, sym};
    if (sh != 0) begin
      shadow_bytes[idx] = shadow_bytes[idx] | 8'(s >> (sh + 1));
      if (idx + 1 < BUF_BYTES)
        shadow_bytes[idx+1] = 8'(s << (7 - sh));
    end else begin
      shadow_bytes[idx] = sym[8:1];
      if (idx + 1 < BUF_BYTES)
        shadow_bytes[idx+1] = {sym[0], 7'b0};
    end
    fill_bits += 9;
    if (fill_bits >= NINE_FLUSH_AT) begin
      full_flushes++;
      send_buffer();
    end
  endfunction

  function automatic void pack_byte8(logic [7:0] d);
    shadow_bytes[fill_bits >> 3] = d;
    fill_bits += 8;
    if (fill_bits >= BUF_BITS) begin
      full_flushes++;
      send_buffer();
    end
  endfunction

  // Command in eight-bit mode: buffer goes first, then a command-level transfer.
  // A sixteen-bit command puts its high byte in bits 7..0 (sent first).
  function automatic void send_command(logic [15:0] v, logic wide);
    send_buffer();
    if (wide)
      expected_words.push_back('{word: {16'b0, v[7:0], v[15:8]},
                                 bit_length_minus_one: sdbp_pkg::CMD16_LEN,
                                 dc_level: 1'b0, last_word: 1'b1, last: 1'b0});
    else
      expected_words.push_back('{word: {24'b0, v[7:0]},
                                 bit_length_minus_one: sdbp_pkg::CMD8_LEN,
                                 dc_level: 1'b0, last_word: 1'b1, last: 1'b0});
  endfunction

  function automatic void predict_item(sdbp_pkg::in_item_t it);
    int unsigned         n_prior;
    sdbp_pkg::out_item_t tail;
    n_prior = expected_words.size();
    case (sdbp_pkg::opcode_e'(it.opcode))
      sdbp_pkg::OP_FLUSH: send_buffer();
      sdbp_pkg::OP_DATA: begin
        if (nine_mode) pack_symbol9(sdbp_pkg::DATA_FLAG | {1'b0, it.value[7:0]});
        else           pack_byte8(it.value[7:0]);
      end
      sdbp_pkg::OP_CMD8: begin
        if (nine_mode) pack_symbol9({1'b0, it.value[7:0]});
        else           send_command(it.value, 1'b0);
      end
      default: begin  // sixteen-bit command
        if (nine_mode) begin
          pack_symbol9({1'b0, it.value[15:8]});
          pack_symbol9({1'b0, it.value[7:0]});
        end else
          send_command(it.value, 1'b1);
      end
    endcase
    // mark the final word this item caused
    if (expected_words.size() > n_prior) begin
      tail      = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  // Mode register: a new value drops any pending bits; same value is a no-op.
  function automatic void predict_mode_write(logic v);
    if (v != nine_mode) begin
      nine_mode = v;
      fill_bits = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items, idles at random, holds a stalled item.
  // The prediction runs at the edge where the item is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_item(in_item_i);
        items_accepted++;
      end
      // a stalled item stays put; otherwise pick the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_items.pop_front();
        end else
          in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken word against the oldest expectation and
  // drives the receiver stall, including the long hold-off on request.
  // --------------------------------------------------------------------------
  int unsigned hold_used = 0;
  int unsigned hold_left = 0;

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_word(sdbp_pkg::out_item_t got);
    sdbp_pkg::out_item_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: word with nothing expected, expected none, actual %h",
               $time, got);
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (got.word !== want.word)
      report_field("word", want.word, got.word);
    if (got.bit_length_minus_one !== want.bit_length_minus_one)
      report_field("bit_length_minus_one", want.bit_length_minus_one,
                   got.bit_length_minus_one);
    if (got.dc_level !== want.dc_level)
      report_field("dc_level", want.dc_level, got.dc_level);
    if (got.last_word !== want.last_word)
      report_field("last_word", want.last_word, got.last_word);
    if (got.last !== want.last)
      report_field("last", want.last, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        check_word(out_item_o);
      if (hold_used != hold_tokens) begin
        hold_used   <= hold_tokens;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake on either side ends the run.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_item(sdbp_pkg::opcode_e op, logic [15:0] v);
    pending_items.push_back('{opcode: op, value: v});
    items_queued++;
  endtask

  // Wait until every item is taken and every word seen, then let data bytes
  // that cause no word drain through the queue before touching the register.
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    predict_mode_write(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Runs of data bytes closed by a command or flush. Long runs can reach the
  // full-buffer flush in either mode; empty runs can give flushes of nothing.
  task automatic add_traffic(int unsigned n);
    int unsigned added, run_len, k;
    added = 0;
    while (added < n) begin
      if ($urandom_range(3) == 0) run_len = $urandom_range(70, 50);
      else                        run_len = $urandom_range(6);
      for (k = 0; k < run_len; k++)
        add_item(sdbp_pkg::OP_DATA, 16'($urandom));
      case ($urandom_range(2))
        0:       add_item(sdbp_pkg::OP_CMD8, 16'($urandom));
        1:       add_item(sdbp_pkg::OP_CMD16, 16'($urandom));
        default: add_item(sdbp_pkg::OP_FLUSH, 16'($urandom));
      endcase
      added += run_len + 1;
    end
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int unsigned k;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, eight-bit mode (reset value) ---
    set_idling(0, 0);
    add_item(sdbp_pkg::OP_FLUSH, 16'h0000);   // empty buffer: no word
    add_item(sdbp_pkg::OP_DATA,  16'hAB00);   // high value bits ignored
    add_item(sdbp_pkg::OP_DATA,  16'h00FF);
    add_item(sdbp_pkg::OP_DATA,  16'hFF5A);
    add_item(sdbp_pkg::OP_FLUSH, 16'hFFFF);   // 24-bit transfer
    add_item(sdbp_pkg::OP_CMD8,  16'hFFA5);   // command with nothing buffered
    add_item(sdbp_pkg::OP_DATA,  16'h1234);
    add_item(sdbp_pkg::OP_CMD16, 16'hFFFF);   // flushes one byte first
    add_item(sdbp_pkg::OP_CMD16, 16'h0000);
    add_item(sdbp_pkg::OP_DATA,  16'h5555);
    add_item(sdbp_pkg::OP_CMD8,  16'h0000);

    // --- directed, nine-bit mode ---
    write_mode(1'b1);
    add_item(sdbp_pkg::OP_DATA,  16'hFF00);
    add_item(sdbp_pkg::OP_CMD8,  16'h00FF);
    add_item(sdbp_pkg::OP_CMD16, 16'h8001);   // two symbols, high byte first
    add_item(sdbp_pkg::OP_DATA,  16'hFFFF);
    add_item(sdbp_pkg::OP_FLUSH, 16'h0000);   // 45 bits over two words
    add_item(sdbp_pkg::OP_FLUSH, 16'h0000);   // empty again
    add_item(sdbp_pkg::OP_DATA,  16'h7E81);
    add_item(sdbp_pkg::OP_CMD16, 16'h00FF);
    write_mode(1'b1);                         // same value keeps the 27 pending bits
    add_item(sdbp_pkg::OP_DATA,  16'h0F0F);
    add_item(sdbp_pkg::OP_FLUSH, 16'h0000);
    add_item(sdbp_pkg::OP_DATA,  16'hC3C3);
    write_mode(1'b0);                         // mode change drops the pending symbol
    add_item(sdbp_pkg::OP_DATA,  16'h0001);
    add_item(sdbp_pkg::OP_FLUSH, 16'h0000);

    // --- random phases with varying back-pressure ---
    wait_idle();
    add_traffic(45);                // eight-bit, no idling

    write_mode(1'b1);
    set_idling(60, 0);
    add_traffic(45);

    write_mode(1'b1);
    set_idling(0, 60);
    add_traffic(45);

    write_mode(1'b0);
    set_idling(16, 16);
    add_traffic(45);

    // long receiver hold-off while the sender keeps pushing commands and data bytes:
    // the output stays stuck, the queue fills and the input stalls
    write_mode(1'b0);
    set_idling(0, 0);
    hold_tokens++;
    for (k = 0; k < 40; k++) begin
      if ($urandom_range(1) != 0) add_item(sdbp_pkg::OP_CMD8, 16'($urandom));
      else                        add_item(sdbp_pkg::OP_DATA, 16'($urandom));
    end

    write_mode(1'b1);
    add_traffic(25);
    add_item(sdbp_pkg::OP_FLUSH, 16'($urandom));

    wait_idle();
    $display("tb: %0d items in, %0d words checked, %0d full-buffer flushes",
             items_accepted, words_checked, full_flushes);
    $display("tb: both symbol modes, commands, flushes and a long output hold-off");
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
